// ===== rtl/core/rht_pkg.sv =====
// Shared types and constants for the reference-counted handle table.
// No dependencies; imported by rht_alloc and refcounted_handle_table_top.
package rht_pkg;

	// Operation codes carried in the input transaction
	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_UNREF  = 2'd2,
		OP_GET    = 2'd3
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_ABSENT = 2'd1,
		STAT_RANGE  = 2'd2,
		STAT_FULL   = 2'd3
	} status_t;

	// Stream field widths
	localparam int OP_W       = 2;
	localparam int IDX_W      = 16;
	localparam int VAL_W      = 64;
	localparam int RIDX_W     = 8;
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 80;

	// Free-slot search: allocation marks are scanned in groups of this size
	localparam int GROUP_W  = 64;
	localparam int GROUP_BW = 6;

endpackage

// ===== rtl/core/rht_ram.sv =====
// Simple dual-port synchronous RAM, one write and one read port, registered read.
// No dependencies.
module rht_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/rht_alloc.sv =====
// Allocation marks with registered lookup and a two-stage lowest-free search.
// Depends on rht_pkg (GROUP_W, GROUP_BW).
module rht_alloc import rht_pkg::*; #(
	parameter int SLOTS = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [$clog2(SLOTS)-1:0] rd_idx,
	output logic                     rd_bit,
	input  logic                     wr_en,
	input  logic [$clog2(SLOTS)-1:0] wr_idx,
	input  logic                     wr_val,
	output logic                     free_found,
	output logic [$clog2(SLOTS)-1:0] free_slot
);

	localparam int IW   = $clog2(SLOTS);
	localparam int NG   = (SLOTS + GROUP_W - 1) / GROUP_W;
	localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
	localparam int NGP  = 1 << GW;
	localparam int PADW = NGP * GROUP_W;

	logic [SLOTS-1:0]    alloc_q;
	logic [PADW-1:0]     alloc_pad;
	logic [NGP-1:0]      grp_free;
	logic [NGP-1:0]      grp_free_s1;
	logic [GW-1:0]       grp_pick;
	logic [GW-1:0]       grp_s2;
	logic                grp_found_s2;
	logic [GROUP_W-1:0]  slice;
	logic [GROUP_BW-1:0] bit_pick;

	// slots past the end read as taken
	always_comb begin
		alloc_pad = '1;
		alloc_pad[SLOTS-1:0] = alloc_q;
	end

	always_comb begin
		for (int g = 0; g < NGP; g++) begin
			grp_free[g] = ~&alloc_pad[g*GROUP_W +: GROUP_W];
		end
	end

	always_comb begin
		grp_pick = '0;
		for (int g = NGP - 1; g >= 0; g--) begin
			if (grp_free_s1[g]) begin
				grp_pick = GW'(g);
			end
		end
	end

	always_comb begin
		for (int b = 0; b < GROUP_W; b++) begin
			slice[b] = alloc_pad[{grp_s2, GROUP_BW'(b)}];
		end
		bit_pick = '0;
		for (int b = GROUP_W - 1; b >= 0; b--) begin
			if (!slice[b]) begin
				bit_pick = GROUP_BW'(b);
			end
		end
	end

	assign free_found = grp_found_s2;
	assign free_slot  = IW'({grp_s2, bit_pick});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q <= '0;
		end else if (wr_en) begin
			alloc_q[wr_idx] <= wr_val;
		end
	end

	// search pipeline runs freely; marks are stable while an add is in flight
	always_ff @(posedge clk) begin
		rd_bit       <= alloc_q[rd_idx];
		grp_free_s1  <= grp_free;
		grp_s2       <= grp_pick;
		grp_found_s2 <= |grp_free_s1;
	end

endmodule

// ===== rtl/core/refcounted_handle_table_top.sv =====
// Top level of the reference-counted handle table.
// Depends on rht_pkg, rht_ram and rht_alloc.
//
// A table of SLOTS handles. Each slot holds an allocated mark (flip-flops,
// cleared by reset), a present mark and reference count (one RAM) and a data
// word (a second RAM). One transaction on the input stream is one operation:
// add claims the lowest free slot, stores the word with count 1 and answers
// the slot number (or table full); remove clears present and drops a
// reference; unref drops a reference; get returns the word and adds a
// reference, saturating at the count maximum. A slot is freed when its count
// reaches zero. Every operation gives exactly one output transaction.
// Sequencing: remove, unref and get do a RAM read, then modify and write back;
// add goes through the two-stage free-slot search and then writes back
// (group scan, then bit scan inside the chosen 64-slot group). One operation
// is in flight at a time; the next one is accepted in the cycle after the
// previous write-back, while its result may still sit in the output register.
// A stalled output holds the write-back until the output register frees up.
// No clearing pass after reset: slots not marked allocated read as empty.
module refcounted_handle_table_top import rht_pkg::*; #(
	parameter int SLOTS       = 256,
	parameter int WORD_WIDTH  = 64,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [1:0] operation, [17:2] slot_index, [81:18] entry_value, [87:82] zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [1:0] status, [9:2] result_index, [73:10] result_value, [79:74] zero
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = COUNT_WIDTH;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_GRP  = 4'b0010,
		ST_BIT  = 4'b0100,
		ST_EXEC = 4'b1000
	} state_t;

	state_t state_q;

	// input transaction fields
	op_t                   op_in;
	logic [IDX_W-1:0]      idx_in;
	logic [VAL_W-1:0]      val_in;
	logic                  accept;

	// captured operation
	op_t                   op_q;
	logic [IW-1:0]         idx_q;
	logic                  range_ok_q;
	logic [WORD_WIDTH-1:0] word_q;

	// storage ports
	logic [CW:0]           meta_rd;
	logic [WORD_WIDTH-1:0] word_rd;
	logic                  alloc_rd;
	logic [IW-1:0]         alloc_rd_idx;
	logic                  free_found;
	logic [IW-1:0]         free_slot;

	logic                  meta_we;
	logic [CW:0]           meta_wd;
	logic                  word_we;
	logic                  alloc_we;
	logic                  alloc_wv;
	logic [IW-1:0]         wr_addr;

	// slot view and result
	logic                  slot_alloc;
	logic                  slot_present;
	logic [CW-1:0]         slot_count;
	logic [CW-1:0]         count_dec;
	logic [CW-1:0]         count_inc;
	status_t               res_status;
	logic [RIDX_W-1:0]     res_index;
	logic [WORD_WIDTH-1:0] res_value;
	logic                  out_free;
	logic                  finish;

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	assign op_in  = op_t'(s_tdata[1:0]);
	assign idx_in = s_tdata[17:2];
	assign val_in = s_tdata[81:18];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign finish   = ((state_q == ST_BIT) || (state_q == ST_EXEC)) && out_free;

	// mark lookup stays on the captured slot while the operation waits to retire
	assign alloc_rd_idx = s_tready ? idx_in[IW-1:0] : idx_q;

	rht_ram #(
		.DEPTH(SLOTS),
		.WIDTH(CW + 1)
	) u_meta_ram (
		.clk    (clk),
		.wr_en  (meta_we),
		.wr_addr(wr_addr),
		.wr_data(meta_wd),
		.rd_en  (accept),
		.rd_addr(idx_in[IW-1:0]),
		.rd_data(meta_rd)
	);

	rht_ram #(
		.DEPTH(SLOTS),
		.WIDTH(WORD_WIDTH)
	) u_word_ram (
		.clk    (clk),
		.wr_en  (word_we),
		.wr_addr(wr_addr),
		.wr_data(word_q),
		.rd_en  (accept),
		.rd_addr(idx_in[IW-1:0]),
		.rd_data(word_rd)
	);

	rht_alloc #(
		.SLOTS(SLOTS)
	) u_alloc (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_idx    (alloc_rd_idx),
		.rd_bit    (alloc_rd),
		.wr_en     (alloc_we),
		.wr_idx    (wr_addr),
		.wr_val    (alloc_wv),
		.free_found(free_found),
		.free_slot (free_slot)
	);

	// an unallocated slot reads as empty whatever the RAM holds
	assign slot_alloc   = alloc_rd;
	assign slot_present = meta_rd[CW] && alloc_rd;
	assign slot_count   = alloc_rd ? meta_rd[CW-1:0] : '0;
	assign count_dec    = (slot_count != '0) ? slot_count - 1'b1 : '0;
	assign count_inc    = (slot_count != '1) ? slot_count + 1'b1 : slot_count;
	assign wr_addr      = (state_q == ST_BIT) ? free_slot : idx_q;

	always_comb begin
		res_status = STAT_OK;
		res_index  = '0;
		res_value  = '0;
		meta_we    = 1'b0;
		meta_wd    = '0;
		word_we    = 1'b0;
		alloc_we   = 1'b0;
		alloc_wv   = 1'b0;
		if (state_q == ST_BIT) begin
			if (!free_found) begin
				res_status = STAT_FULL;
			end else begin
				res_index = RIDX_W'(free_slot);
				meta_we   = finish;
				meta_wd   = {1'b1, CW'(1)};
				word_we   = finish;
				alloc_we  = finish;
				alloc_wv  = 1'b1;
			end
		end else if (state_q == ST_EXEC) begin
			if (!range_ok_q) begin
				res_status = STAT_RANGE;
			end else begin
				unique case (op_q)
					OP_REMOVE: begin
						if (!slot_present) begin
							res_status = STAT_ABSENT;
						end else begin
							meta_we  = finish;
							meta_wd  = {1'b0, count_dec};
							alloc_we = finish && (count_dec == '0);
						end
					end
					OP_UNREF: begin
						if (!slot_alloc) begin
							res_status = STAT_ABSENT;
						end else begin
							meta_we  = finish;
							meta_wd  = {slot_present, count_dec};
							alloc_we = finish && (count_dec == '0);
						end
					end
					OP_GET: begin
						if (!slot_present) begin
							res_status = STAT_ABSENT;
						end else begin
							res_value = word_rd;
							meta_we   = finish;
							meta_wd   = {1'b1, count_inc};
						end
					end
					OP_ADD: begin
						res_status = STAT_OK;
					end
					default: begin
						res_status = STAT_OK;
					end
				endcase
			end
		end
	end

	// sequencer: add goes through the free search, the rest straight to exec
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (op_in == OP_ADD) ? ST_GRP : ST_EXEC;
					end
				end
				ST_GRP: begin
					state_q <= ST_BIT;
				end
				ST_BIT, ST_EXEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= op_in;
			idx_q      <= idx_in[IW-1:0];
			range_ok_q <= (32'(idx_in) < SLOTS);
			word_q     <= val_in[WORD_WIDTH-1:0];
		end
	end

	// output register decouples the result from the next operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			m_tdata_q <= {6'b0, VAL_W'(res_value), res_index, res_status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
